### sv/cirs_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and arithmetic helpers of the colored ICP residual sum block.
package cirs_pkg;

    localparam int AXES     = 3;
    localparam int COORD_W  = 21;
    localparam int VEC_W    = AXES * COORD_W;
    localparam int CHAN_W   = 16;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int WEIGHT_W = 17;
    localparam int CFG_IDX_W = 8;
    localparam int ACC_W    = 63;

    // Datapath widths, sized from the value ranges of each step
    localparam int D_W       = COORD_W + 1;
    localparam int PROD1_W   = D_W + COORD_W;
    localparam int G32_W     = PROD1_W + 2;
    localparam int G16_W     = 29;
    localparam int PROD2_W   = G16_W + COORD_W;
    localparam int P_W       = 33;
    localparam int PROD3_W   = P_W + COORD_W;
    localparam int DOT_W     = PROD3_W + 2;
    localparam int CSUM_W    = CHAN_W + 2;
    localparam int DS_W      = CSUM_W + 1;
    localparam int NUM_W     = 57;
    localparam int DIV_W     = 40;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DF_W      = 38;
    localparam int WG_PROD_W = WEIGHT_W + 1 + G16_W;
    localparam int WP_PROD_W = WEIGHT_W + 1 + DF_W;
    localparam int MAG_W     = 39;
    localparam int SQ_IN_W   = 32;

    // reciprocal of three, ceil(2^42 / 3); exact quotient for any 40-bit dividend
    localparam int RECIP_W     = 41;
    localparam int RECIP_SHIFT = 42;
    localparam logic [RECIP_W-1:0] RECIP3 = 41'h155_5555_5556;

    localparam int FRAC_SHIFT = 16;
    localparam int DS_SHIFT   = 17;

    localparam logic [ACC_W-1:0] ACC_MAX      = '1;
    localparam logic [MAG_W-1:0] SQRT_ACC_MAX = MAG_W'(64'd3037000499);
    // half of 3 * 2^16, rounding bias ahead of the divide by 3 * 2^16
    localparam logic [NUM_W-1:0] DIV_BIAS     = NUM_W'(98304);

    localparam logic [CFG_IDX_W-1:0] REG_GEOMETRIC_WEIGHT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PHOTOMETRIC_WEIGHT = CFG_IDX_W'(1);

    localparam logic [WEIGHT_W-1:0] GEOMETRIC_WEIGHT_RESET   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] PHOTOMETRIC_WEIGHT_RESET = 17'd0;

    typedef struct packed {
        logic [VEC_W-1:0]   source_point;
        logic [VEC_W-1:0]   target_point;
        logic [VEC_W-1:0]   target_normal;
        logic [VEC_W-1:0]   target_gradient;
        logic [COLOR_W-1:0] source_color;
        logic [COLOR_W-1:0] target_color;
        logic               is_last;
    } cirs_item_t;

    typedef struct packed {
        logic [ACC_W-1:0] residual_sum;
        logic             saturated;
    } cirs_result_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic grnd;
        logic mul2;
        logic proj;
        logic mul3;
        logic dot;
        logic num;
        logic pred;
        logic div_step;
        logic fix;
        logic mulw;
        logic rndw;
        logic sq;
        logic acc;
    } cirs_cmd_t;

    typedef struct packed {
        logic last;
        logic result_busy;
    } cirs_status_t;

    // x / 2^16 rounded to nearest, ties away from zero
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
        logic [63:0] ux;
        logic [63:0] mag;
        logic [63:0] q;
        ux  = x;
        mag = x[63] ? (64'd0 - ux) : ux;
        q   = (mag + 64'd32768) >> FRAC_SHIFT;
        rnd16 = x[63] ? (64'd0 - q) : q;
    endfunction

    function automatic logic [CSUM_W-1:0] chan_sum(input logic [COLOR_W-1:0] c);
        chan_sum = CSUM_W'(c[CHAN_W-1:0]) + CSUM_W'(c[2*CHAN_W-1:CHAN_W])
                 + CSUM_W'(c[3*CHAN_W-1:2*CHAN_W]);
    endfunction

endpackage

### sv/cirs_div3.sv
`timescale 1ns / 1ps
// Divide-by-three unit: reciprocal multiply, one dividend byte per cycle while step is high.
module cirs_div3 (
    input  logic                       clk,
    input  logic                       load,
    input  logic                       step,
    input  logic [cirs_pkg::DIV_W-1:0] dividend,
    output logic [cirs_pkg::DIV_W-1:0] quotient
);

    localparam int PART_W = cirs_pkg::DIV_BITS + cirs_pkg::RECIP_W;
    localparam int PROD_W = cirs_pkg::DIV_W + cirs_pkg::RECIP_W;

    // dividend bytes leave at the top, the product moves up a byte and takes the next partial
    logic [cirs_pkg::DIV_W-1:0] work_reg, work_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [PART_W-1:0]          part;

    always_comb
    begin
        work_next = work_reg;
        prod_next = prod_reg;
        part      = PART_W'(work_reg[cirs_pkg::DIV_W-1 -: cirs_pkg::DIV_BITS])
                  * PART_W'(cirs_pkg::RECIP3);
        if (load)
        begin
            work_next = dividend;
            prod_next = '0;
        end
        else if (step)
        begin
            work_next = work_reg << cirs_pkg::DIV_BITS;
            prod_next = (prod_reg << cirs_pkg::DIV_BITS) + PROD_W'(part);
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        prod_reg <= prod_next;
    end

    assign quotient = cirs_pkg::DIV_W'(prod_reg >> cirs_pkg::RECIP_SHIFT);

endmodule

### sv/cirs_datapath.sv
`timescale 1ns / 1ps
// Datapath: residual arithmetic, weights, saturating accumulator and result register.
module cirs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cirs_pkg::cirs_cmd_t            cmd,
    output cirs_pkg::cirs_status_t         status,
    input  cirs_pkg::cirs_item_t           item,
    input  logic                           cfg_valid,
    input  logic [cirs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cirs_pkg::WEIGHT_W-1:0]  cfg_data,
    output logic                           result_valid,
    input  logic                           result_ready,
    output cirs_pkg::cirs_result_t         result
);

    localparam int AXES    = cirs_pkg::AXES;
    localparam int COORD_W = cirs_pkg::COORD_W;

    logic [cirs_pkg::WEIGHT_W-1:0] wg_reg, wg_next;
    logic [cirs_pkg::WEIGHT_W-1:0] wp_reg, wp_next;

    logic signed [cirs_pkg::D_W-1:0]     d_reg     [AXES];
    logic signed [cirs_pkg::D_W-1:0]     d_next    [AXES];
    logic signed [COORD_W-1:0]           n_reg     [AXES];
    logic signed [COORD_W-1:0]           n_next    [AXES];
    logic signed [COORD_W-1:0]           grad_reg  [AXES];
    logic signed [COORD_W-1:0]           grad_next [AXES];
    logic signed [cirs_pkg::PROD1_W-1:0] prod1_reg [AXES];
    logic signed [cirs_pkg::PROD1_W-1:0] prod1_next[AXES];
    logic signed [cirs_pkg::PROD2_W-1:0] prod2_reg [AXES];
    logic signed [cirs_pkg::PROD2_W-1:0] prod2_next[AXES];
    logic signed [cirs_pkg::P_W-1:0]     p_reg     [AXES];
    logic signed [cirs_pkg::P_W-1:0]     p_next    [AXES];
    logic signed [cirs_pkg::PROD3_W-1:0] prod3_reg [AXES];
    logic signed [cirs_pkg::PROD3_W-1:0] prod3_next[AXES];

    logic signed [cirs_pkg::DS_W-1:0]      ds_reg, ds_next;
    logic                                  last_reg, last_next;
    logic signed [cirs_pkg::G16_W-1:0]     g16_reg, g16_next;
    logic signed [cirs_pkg::WG_PROD_W-1:0] wgp_reg, wgp_next;
    logic signed [cirs_pkg::DOT_W-1:0]     dot_reg, dot_next;
    logic signed [cirs_pkg::NUM_W-1:0]     num_reg, num_next;
    logic                                  neg_reg, neg_next;
    logic signed [cirs_pkg::DF_W-1:0]      diff_reg, diff_next;
    logic signed [cirs_pkg::WP_PROD_W-1:0] wpp_reg, wpp_next;
    logic [cirs_pkg::MAG_W-1:0]            mag_reg, mag_next;
    logic [cirs_pkg::ACC_W-1:0]            term_reg, term_next;
    logic [cirs_pkg::ACC_W-1:0]            acc_reg, acc_next;
    logic                                  clip_reg, clip_next;
    logic                                  result_valid_reg, result_valid_next;
    cirs_pkg::cirs_result_t                result_reg, result_next;

    logic [cirs_pkg::DIV_W-1:0] div_dividend;
    logic [cirs_pkg::DIV_W-1:0] div_quotient;

    cirs_div3 u_div3 (
        .clk      (clk),
        .load     (cmd.pred),
        .step     (cmd.div_step),
        .dividend (div_dividend),
        .quotient (div_quotient)
    );

    // shared squarer and saturating adder
    logic                               sq_over;
    logic [2*cirs_pkg::SQ_IN_W-1:0]     sq_full;
    logic [cirs_pkg::ACC_W:0]           acc_sum;
    logic [cirs_pkg::ACC_W-1:0]         acc_add_val;
    logic                               clip_add;

    always_comb
    begin
        sq_over     = mag_reg > cirs_pkg::SQRT_ACC_MAX;
        sq_full     = mag_reg[cirs_pkg::SQ_IN_W-1:0] * mag_reg[cirs_pkg::SQ_IN_W-1:0];
        acc_sum     = {1'b0, acc_reg} + {1'b0, term_reg};
        acc_add_val = acc_sum[cirs_pkg::ACC_W] ? cirs_pkg::ACC_MAX
                                               : acc_sum[cirs_pkg::ACC_W-1:0];
        clip_add    = clip_reg | acc_sum[cirs_pkg::ACC_W];
    end

    always_comb
    begin
        logic signed [cirs_pkg::G32_W-1:0] g32;
        logic signed [63:0]                rw;
        logic [cirs_pkg::NUM_W-1:0]        num_mag;
        logic [cirs_pkg::DF_W-1:0]         q_df;

        wg_next           = wg_reg;
        wp_next           = wp_reg;
        d_next            = d_reg;
        n_next            = n_reg;
        grad_next         = grad_reg;
        prod1_next        = prod1_reg;
        prod2_next        = prod2_reg;
        p_next            = p_reg;
        prod3_next        = prod3_reg;
        ds_next           = ds_reg;
        last_next         = last_reg;
        g16_next          = g16_reg;
        wgp_next          = wgp_reg;
        dot_next          = dot_reg;
        num_next          = num_reg;
        neg_next          = neg_reg;
        diff_next         = diff_reg;
        wpp_next          = wpp_reg;
        mag_next          = mag_reg;
        term_next         = term_reg;
        acc_next          = acc_reg;
        clip_next         = clip_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        g32     = cirs_pkg::G32_W'(prod1_reg[0]) + cirs_pkg::G32_W'(prod1_reg[1])
                + cirs_pkg::G32_W'(prod1_reg[2]);
        rw      = '0;
        num_mag = num_reg[cirs_pkg::NUM_W-1] ? (~num_reg + 1'b1) : num_reg;
        q_df    = div_quotient[cirs_pkg::DF_W-1:0];

        div_dividend = cirs_pkg::DIV_W'((num_mag + cirs_pkg::DIV_BIAS)
                                        >> cirs_pkg::FRAC_SHIFT);

        if (cfg_valid)
        begin
            case (cfg_index)
                cirs_pkg::REG_GEOMETRIC_WEIGHT:   wg_next = cfg_data;
                cirs_pkg::REG_PHOTOMETRIC_WEIGHT: wp_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                d_next[i] = cirs_pkg::D_W'(signed'(item.source_point[i*COORD_W +: COORD_W]))
                          - cirs_pkg::D_W'(signed'(item.target_point[i*COORD_W +: COORD_W]));
                n_next[i]    = signed'(item.target_normal[i*COORD_W +: COORD_W]);
                grad_next[i] = signed'(item.target_gradient[i*COORD_W +: COORD_W]);
            end
            ds_next   = cirs_pkg::DS_W'(cirs_pkg::chan_sum(item.source_color))
                      - cirs_pkg::DS_W'(cirs_pkg::chan_sum(item.target_color));
            last_next = item.is_last;
        end

        if (cmd.mul1)
        begin
            for (int i = 0; i < AXES; i++)
                prod1_next[i] = d_reg[i] * n_reg[i];
        end

        if (cmd.grnd)
            g16_next = cirs_pkg::G16_W'(cirs_pkg::rnd16(64'(g32)));

        if (cmd.mul2)
        begin
            for (int i = 0; i < AXES; i++)
                prod2_next[i] = g16_reg * n_reg[i];
            wgp_next = signed'({1'b0, wg_reg}) * g16_reg;
        end

        // projection onto the tangent plane, and the weighted geometric residual
        if (cmd.proj)
        begin
            for (int i = 0; i < AXES; i++)
                p_next[i] = cirs_pkg::P_W'(64'(d_reg[i])
                                           - cirs_pkg::rnd16(64'(prod2_reg[i])));
            rw       = cirs_pkg::rnd16(64'(wgp_reg));
            mag_next = cirs_pkg::MAG_W'(rw[63] ? -rw : rw);
        end

        if (cmd.mul3)
        begin
            for (int i = 0; i < AXES; i++)
                prod3_next[i] = grad_reg[i] * p_reg[i];
        end

        if (cmd.mul3 || cmd.sq)
        begin
            term_next = sq_over ? cirs_pkg::ACC_MAX : cirs_pkg::ACC_W'(sq_full);
            clip_next = clip_reg | sq_over;
        end

        if (cmd.dot)
        begin
            dot_next  = cirs_pkg::DOT_W'(prod3_reg[0]) + cirs_pkg::DOT_W'(prod3_reg[1])
                      + cirs_pkg::DOT_W'(prod3_reg[2]);
            acc_next  = acc_add_val;
            clip_next = clip_add;
        end

        // 3 * 2^32 * diff = (Ss - St) * 2^17 - 3 * dot
        if (cmd.num)
            num_next = (cirs_pkg::NUM_W'(ds_reg) <<< cirs_pkg::DS_SHIFT)
                     - cirs_pkg::NUM_W'(dot_reg) - (cirs_pkg::NUM_W'(dot_reg) <<< 1);

        if (cmd.pred)
            neg_next = num_reg[cirs_pkg::NUM_W-1];

        if (cmd.fix)
            diff_next = neg_reg ? (~q_df + 1'b1) : q_df;

        if (cmd.mulw)
            wpp_next = signed'({1'b0, wp_reg}) * diff_reg;

        if (cmd.rndw)
        begin
            rw       = cirs_pkg::rnd16(64'(wpp_reg));
            mag_next = cirs_pkg::MAG_W'(rw[63] ? -rw : rw);
        end

        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        if (cmd.acc)
        begin
            if (last_reg)
            begin
                result_next.residual_sum = acc_add_val;
                result_next.saturated    = clip_add;
                result_valid_next        = 1'b1;
                acc_next                 = '0;
                clip_next                = 1'b0;
            end
            else
            begin
                acc_next  = acc_add_val;
                clip_next = clip_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wg_reg           <= cirs_pkg::GEOMETRIC_WEIGHT_RESET;
            wp_reg           <= cirs_pkg::PHOTOMETRIC_WEIGHT_RESET;
            acc_reg          <= '0;
            clip_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            wg_reg           <= wg_next;
            wp_reg           <= wp_next;
            acc_reg          <= acc_next;
            clip_reg         <= clip_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        n_reg      <= n_next;
        grad_reg   <= grad_next;
        prod1_reg  <= prod1_next;
        prod2_reg  <= prod2_next;
        p_reg      <= p_next;
        prod3_reg  <= prod3_next;
        ds_reg     <= ds_next;
        last_reg   <= last_next;
        g16_reg    <= g16_next;
        wgp_reg    <= wgp_next;
        dot_reg    <= dot_next;
        num_reg    <= num_next;
        neg_reg    <= neg_next;
        diff_reg   <= diff_next;
        wpp_reg    <= wpp_next;
        mag_reg    <= mag_next;
        term_reg   <= term_next;
        result_reg <= result_next;
    end

    assign status.last        = last_reg;
    assign status.result_busy = result_valid_reg && !result_ready;
    assign result_valid       = result_valid_reg;
    assign result             = result_reg;

endmodule

### sv/cirs_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one request through the datapath steps.
module cirs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  cirs_pkg::cirs_status_t status,
    output cirs_pkg::cirs_cmd_t    cmd
);

    typedef enum logic [14:0] {
        ST_IDLE = 15'b1 << 0,
        ST_MUL1 = 15'b1 << 1,
        ST_GRND = 15'b1 << 2,
        ST_MUL2 = 15'b1 << 3,
        ST_PROJ = 15'b1 << 4,
        ST_MUL3 = 15'b1 << 5,
        ST_DOT  = 15'b1 << 6,
        ST_NUM  = 15'b1 << 7,
        ST_PRED = 15'b1 << 8,
        ST_DIV  = 15'b1 << 9,
        ST_FIX  = 15'b1 << 10,
        ST_MULW = 15'b1 << 11,
        ST_RNDW = 15'b1 << 12,
        ST_SQ   = 15'b1 << 13,
        ST_ACC  = 15'b1 << 14
    } state_t;

    state_t                         state_reg, state_next;
    logic [cirs_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                           acc_stall;

    // the final add waits while an earlier sum is still unclaimed
    assign acc_stall  = status.last && status.result_busy;
    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_GRND;
            end
            ST_GRND:
            begin
                cmd.grnd   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                cmd.proj   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = ST_DOT;
            end
            ST_DOT:
            begin
                cmd.dot    = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.num    = 1'b1;
                state_next = ST_PRED;
            end
            ST_PRED:
            begin
                cmd.pred     = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == cirs_pkg::DIV_CNT_W'(cirs_pkg::DIV_STEPS - 1))
                    state_next = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_MULW;
            end
            ST_MULW:
            begin
                cmd.mulw   = 1'b1;
                state_next = ST_RNDW;
            end
            ST_RNDW:
            begin
                cmd.rndw   = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!acc_stall)
                begin
                    cmd.acc    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

### sv/colored_icp_residual_sum.sv
`timescale 1ns / 1ps
// Colored ICP residual sum: one correspondence per request, sum emitted on the last one.
// A new request is taken only after the previous one has gone through every step. The sum
// is registered and valid after the accumulate step of the last request only. The steps
// include the divide-by-three unit, which multiplies 8 dividend bits by the reciprocal
// of three per cycle. A pending unclaimed result stalls the last add.
// Reset: weights to 1.0 and 0.0, accumulator and clip flag cleared, no result pending.
module colored_icp_residual_sum (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  cirs_pkg::cirs_item_t           item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output cirs_pkg::cirs_result_t         result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cirs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cirs_pkg::WEIGHT_W-1:0]  cfg_data
);

    cirs_pkg::cirs_cmd_t    cmd;
    cirs_pkg::cirs_status_t status;

    assign cfg_ready = 1'b1;

    cirs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    cirs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
